### rtl/sau_pkg.sv
// shared constants, types and the logistic curve table of the sigmoid activation unit
package sau_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int FRACTION_BITS = 16;
  localparam int IO_FRAC       = 16;

  localparam int POT_W       = 32;
  localparam int ACT_W       = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // doubled difference, its product with the slope and the scaled argument
  localparam int DIFF_W  = POT_W + 2;
  localparam int SMAG_W  = POT_W;
  localparam int PROD_W  = DIFF_W + SMAG_W;
  localparam int T_SHIFT = 2 * IO_FRAC - FRACTION_BITS;
  localparam int PSH_W   = PROD_W - T_SHIFT;
  localparam int TMAG_W  = FRACTION_BITS + 8;

  // table addressing
  localparam int U_W   = FRACTION_BITS + 4;
  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
  localparam int POS_W = U_W + IDX_W;

  // linear ramp
  localparam int XMAG_W     = TMAG_W - 1;
  localparam int LIN_GAIN_W = 31;
  localparam int LIN_PROD_W = XMAG_W + LIN_GAIN_W;
  localparam int LIN_SHIFT  = IO_FRAC + FRACTION_BITS;
  localparam int M_W        = LIN_PROD_W - LIN_SHIFT;

  localparam logic [ACT_W-1:0]      ONE_Q16  = ACT_W'(65536);
  localparam logic [ACT_W-1:0]      HALF_Q16 = ACT_W'(32768);
  localparam logic [TMAG_W-1:0]     T_CAP    = TMAG_W'(128) << FRACTION_BITS;
  localparam logic [LIN_GAIN_W-1:0] LIN_GAIN = LIN_GAIN_W'(1954723855);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REST     = 3'd0,
    REG_THRESH   = 3'd1,
    REG_SLOPE    = 3'd2,
    REG_SIG_MODE = 3'd3,
    REG_INVERT   = 3'd4
  } cfg_reg_t;

  // load enables of the two shaping stages
  typedef struct packed {
    logic lookup;
    logic interp;
  } sau_step_t;

  typedef logic [ACT_W-1:0] curve_t [0:TABLE_ENTRIES];

  // long division, only evaluated while the constant table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // g(u) = 1/(1+exp(u)) in q0.16 at u = 16k/entries, built with q.56 integer maths
  function automatic curve_t build_curve();
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] p40;
    logic [63:0] den;
    logic [63:0] mask;
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    curve_t      c;
    e    = 64'd1 << 56;
    term = 64'd1 << 56;
    p    = 64'd1 << 56;
    mask = (64'd1 << 28) - 64'd1;
    for (int n = 1; n < 40; n++) begin
      term = udiv64(term * 64'd16, 64'(TABLE_ENTRIES) * 64'(n));
      if ((n & 1) != 0) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      p40  = p >> 16;
      den  = (64'd1 << 40) + p40;
      c[k] = ACT_W'(udiv64((p40 << 16) + (den >> 1), den));
      ah   = p >> 28;
      al   = p & mask;
      bh   = e >> 28;
      bl   = e & mask;
      p    = ah * bh + ((ah * bl + al * bh) >> 28);
    end
    return c;
  endfunction

  localparam curve_t CURVE = build_curve();

endpackage

### rtl/sigmoid_activation_unit.sv
// sigmoid activation unit top level: config registers, argument pipeline and output register
//
//  channel   direction  handshake                  payload
//  s_*       in         s_tvalid / s_tready        s_tdata: potential
//  m_*       out        m_tvalid / m_tready        m_tdata: activity
//  cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// six pipeline stages: one item accepted per cycle unless a stalled output has filled them;
// a taken request passes the stage 1 to 5 registers and then sets m_tvalid in stage 6
// the 34 x 32 product of doubled difference and slope gain sets the stage depth
// reset clears valid bits and loads register defaults; the curve table is constant
// a stalled output holds the full stages while empty stages ahead still take requests
// cfg_ready is always high; the registers apply to every later request
module sigmoid_activation_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sau_pkg::IN_TDATA_W-1:0]       s_tdata,  // [31:0] potential
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sau_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [16:0] activity, [23:17] zero
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sau_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sau_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sau_pkg::*;

  logic signed [POT_W-1:0] rest_potential;
  logic signed [POT_W-1:0] threshold_rest_potential;
  logic signed [POT_W-1:0] slope_gain;
  logic                    true_sigmoid_mode;
  logic                    invert_output;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        dmag1;
  logic                     dneg1;

  logic [SMAG_W-1:0]        smag;
  logic [PROD_W-1:0]        prod2;
  logic                     neg2;

  logic [PSH_W-1:0]         shifted;
  logic [TMAG_W-1:0]        tmag_next;
  logic [TMAG_W-1:0]        tmag3;
  logic                     neg3;

  sau_step_t                step;
  logic [ACT_W-1:0]         sig5;
  logic [ACT_W-1:0]         lin5;
  logic [ACT_W-1:0]         pick;
  logic [ACT_W-1:0]         activity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_potential           <= '0;
      threshold_rest_potential <= POT_W'(65536);
      slope_gain               <= '0;
      true_sigmoid_mode        <= 1'b0;
      invert_output            <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REST:     rest_potential           <= cfg_data;
        REG_THRESH:   threshold_rest_potential <= cfg_data;
        REG_SLOPE:    slope_gain               <= cfg_data;
        REG_SIG_MODE: true_sigmoid_mode        <= cfg_data[0];
        REG_INVERT:   invert_output            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  assign en6      = !m_tvalid || m_tready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) m_tvalid <= v5;
    end
  end

  // stage 1: 2*potential - (rest + threshold), as sign and magnitude
  assign diff = (DIFF_W'(signed'(s_tdata[POT_W-1:0])) <<< 1)
              - (DIFF_W'(rest_potential) + DIFF_W'(threshold_rest_potential));

  always_ff @(posedge clk) begin
    if (en1) begin
      dneg1 <= diff[DIFF_W-1];
      dmag1 <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end
  end

  // stage 2: magnitude product with the slope
  assign smag = slope_gain[POT_W-1] ? SMAG_W'(-slope_gain) : SMAG_W'(slope_gain);

  always_ff @(posedge clk) begin
    if (en2) begin
      prod2 <= PROD_W'(dmag1) * PROD_W'(smag);
      neg2  <= dneg1 ^ slope_gain[POT_W-1];
    end
  end

  // stage 3: truncate to the argument format and cap its magnitude
  assign shifted   = prod2[PROD_W-1:T_SHIFT];
  assign tmag_next = (shifted > PSH_W'(T_CAP)) ? T_CAP : shifted[TMAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en3) begin
      tmag3 <= tmag_next;
      neg3  <= neg2 && (tmag_next != '0);
    end
  end

  // stages 4 and 5
  assign step.lookup = en4;
  assign step.interp = en5;

  sau_shape u_shape (
    .clk  (clk),
    .step (step),
    .tmag (tmag3),
    .neg  (neg3),
    .sig  (sig5),
    .lin  (lin5)
  );

  // stage 6: mode select, optional inversion, output register
  assign pick = true_sigmoid_mode ? sig5 : lin5;

  always_ff @(posedge clk) begin
    if (en6) begin
      activity <= invert_output ? (ONE_Q16 - pick) : pick;
    end
  end

  assign m_tdata = OUT_TDATA_W'(activity);

  // the input side only waits behind a blocked output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked output");

  // results stay on the unit interval
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (activity <= ONE_Q16))
    else $error("activity above one");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !v5) |=> !m_tvalid)
    else $error("result repeated after drain");

  // a full pipeline under a blocked output takes no request
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken into a full pipeline");

endmodule

### rtl/sau_shape.sv
// table lookup with interpolation and the clamped linear ramp, two pipeline stages
module sau_shape (
  input  logic                           clk,
  input  sau_pkg::sau_step_t             step,
  input  logic [sau_pkg::TMAG_W-1:0]     tmag,
  input  logic                           neg,
  output logic [sau_pkg::ACT_W-1:0]      sig,
  output logic [sau_pkg::ACT_W-1:0]      lin
);
  import sau_pkg::*;

  // lookup stage
  logic                  beyond_in;
  logic [U_W-1:0]        u;
  logic [POS_W-1:0]      pos;
  logic [IDX_W-1:0]      idx_raw;
  logic [IDX_W-1:0]      idx;

  logic [ACT_W-1:0]      a4;
  logic [ACT_W-1:0]      b4;
  logic [U_W-1:0]        frac4;
  logic                  beyond4;
  logic                  neg4;
  logic [LIN_PROD_W-1:0] lin_prod4;

  // interpolation stage
  logic                    desc;
  logic [ACT_W-1:0]        delta;
  logic [ACT_W+U_W-1:0]    dprod;
  logic [ACT_W-1:0]        dstep;
  logic [ACT_W-1:0]        g;
  logic [M_W-1:0]          m;
  logic                    m_big;
  logic [ACT_W-1:0]        sig_next;
  logic [ACT_W-1:0]        lin_next;

  assign beyond_in = |tmag[TMAG_W-1:U_W];
  assign u         = tmag[U_W-1:0];
  assign pos       = POS_W'(u) * POS_W'(TABLE_ENTRIES);
  assign idx_raw   = pos[POS_W-1:U_W];
  assign idx       = (idx_raw >= IDX_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1) : idx_raw;

  always_ff @(posedge clk) begin
    if (step.lookup) begin
      a4        <= CURVE[idx];
      b4        <= CURVE[idx + IDX_W'(1)];
      frac4     <= pos[U_W-1:0];
      beyond4   <= beyond_in;
      neg4      <= neg;
      lin_prod4 <= LIN_PROD_W'(tmag[TMAG_W-1:1]) * LIN_PROD_W'(LIN_GAIN);
    end
  end

  assign desc  = a4 >= b4;
  assign delta = desc ? (a4 - b4) : (b4 - a4);
  assign dprod = (ACT_W+U_W)'(delta) * (ACT_W+U_W)'(frac4);
  assign dstep = dprod[ACT_W+U_W-1:U_W];
  assign g     = beyond4 ? '0 : (desc ? (a4 - dstep) : (a4 + dstep));

  assign m     = lin_prod4[LIN_PROD_W-1:LIN_SHIFT];
  assign m_big = m >= M_W'(HALF_Q16);

  always_comb begin
    sig_next = neg4 ? (ONE_Q16 - g) : g;
    if (neg4) begin
      lin_next = m_big ? ONE_Q16 : (HALF_Q16 + m[ACT_W-1:0]);
    end else begin
      lin_next = m_big ? '0 : (HALF_Q16 - m[ACT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (step.interp) begin
      sig <= sig_next;
      lin <= lin_next;
    end
  end

endmodule
